/* hw/rtl/dbfb_pkg.sv */
// ----------------------------------------------------------------------------
// dbfb_pkg: shared types and constants of the double-buffered framebuffer
// Holds the command/status structs, status codes, control offsets and
// register indexes used by the controller and the datapath.
// ----------------------------------------------------------------------------
package dbfb_pkg;

	localparam int MAX_BUFFER_BYTES_DEF = 16384;
	localparam int BYTES_PER_PIXEL      = 3;

	localparam int PROD_W  = 19;	// 8x8 pixel product times up to 4 bytes
	localparam int WIN_W   = 17;	// bus window plus one bit for 2S
	localparam int ADDR_W  = 16;
	localparam int DATA_W  = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [7:0] WIDTH_RESET  = 8'd64;
	localparam logic [7:0] HEIGHT_RESET = 8'd64;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DBUF   = 2'd2;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_ADDR = 3'd1,
		ST_INVALID  = 3'd2,
		ST_UNMAPPED = 3'd3,
		ST_NO_BACK  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CTL_CLEAR  = 2'd0,
		CTL_SWAP   = 2'd1,
		CTL_REDRAW = 2'd2,
		CTL_CRASH  = 2'd3
	} ctl_t;

	typedef struct packed {
		logic init_sweep;
		logic accept;
		logic load_rd;
		logic clear_sweep;
	} dbfb_cmd_t;

	typedef struct packed {
		logic is_read;
		logic is_clear;
		logic frame_empty;
		logic init_last;
		logic clear_last;
	} dbfb_stat_t;

endpackage

/* hw/rtl/dbfb_ram.sv */
// ----------------------------------------------------------------------------
// dbfb_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module dbfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/dbfb_ctrl.sv */
// ----------------------------------------------------------------------------
// dbfb_ctrl: framebuffer controller
// Sequences the reset clearing pass, bus accesses, clear sweeps and the
// result handshake.
// ----------------------------------------------------------------------------
module dbfb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  dbfb_pkg::dbfb_stat_t stat,
	output dbfb_pkg::dbfb_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_INIT  = 5'b00001,
		S_IDLE  = 5'b00010,
		S_READ  = 5'b00100,
		S_CLEAR = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.init_sweep = 1'b1;
				if (stat.init_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (stat.is_read) begin
						state_d = S_READ;
					end else if (stat.is_clear && !stat.frame_empty) begin
						state_d = S_CLEAR;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_READ: begin
				cmd.load_rd = 1'b1;
				state_d     = S_RESP;
			end
			S_CLEAR: begin
				cmd.clear_sweep = 1'b1;
				if (stat.clear_last) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/dbfb_dp.sv */
// ----------------------------------------------------------------------------
// dbfb_dp: framebuffer datapath
// Configuration registers, frame size, address decode, the two stores,
// the sweep counter, the front/redraw flags and the result register.
// ----------------------------------------------------------------------------
module dbfb_dp #(
	parameter int MAX_BUFFER_BYTES = dbfb_pkg::MAX_BUFFER_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dbfb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_wdata,
	input  logic                           operation,
	input  logic [dbfb_pkg::ADDR_W-1:0]    address,
	input  logic [dbfb_pkg::DATA_W-1:0]    write_data,
	input  dbfb_pkg::dbfb_cmd_t            cmd,
	output dbfb_pkg::dbfb_stat_t           stat,
	output logic [dbfb_pkg::DATA_W-1:0]    read_data,
	output logic [2:0]                     status,
	output logic                           redraw_pending,
	output logic                           front_select
);

	localparam int AW = $clog2(MAX_BUFFER_BYTES);
	localparam int FW = $clog2(MAX_BUFFER_BYTES + 1);
	localparam int WW = dbfb_pkg::WIN_W;
	localparam int PW = dbfb_pkg::PROD_W;
	localparam int RESET_PROD = 64 * 64 * dbfb_pkg::BYTES_PER_PIXEL;
	localparam int RESET_FRAME = (RESET_PROD > MAX_BUFFER_BYTES) ?
		MAX_BUFFER_BYTES : RESET_PROD;
	localparam logic [PW-1:0] MAX_P = PW'(MAX_BUFFER_BYTES);
	localparam logic [AW-1:0] LAST_ENTRY = AW'(MAX_BUFFER_BYTES - 1);

	logic [7:0]    width_q, height_q, width_d, height_d;
	logic          dbuf_q;
	logic [FW-1:0] frame_q;
	logic [PW-1:0] prod;
	logic [AW-1:0] cnt_q;
	logic          front_is_b_q, redraw_q;
	logic [7:0]    rdata_q;
	logic [2:0]    status_q;

	// Frame size follows the config registers as they are written
	always_comb begin
		width_d  = width_q;
		height_d = height_q;
		if (cfg_we && cfg_index == dbfb_pkg::REG_WIDTH) begin
			width_d = cfg_wdata;
		end
		if (cfg_we && cfg_index == dbfb_pkg::REG_HEIGHT) begin
			height_d = cfg_wdata;
		end
		prod = PW'(width_d) * PW'(height_d) * PW'(dbfb_pkg::BYTES_PER_PIXEL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= dbfb_pkg::WIDTH_RESET;
			height_q <= dbfb_pkg::HEIGHT_RESET;
			dbuf_q   <= 1'b0;
			frame_q  <= FW'(RESET_FRAME);
		end else begin
			width_q  <= width_d;
			height_q <= height_d;
			frame_q  <= (prod > MAX_P) ? FW'(MAX_BUFFER_BYTES) : FW'(prod);
			if (cfg_we && cfg_index == dbfb_pkg::REG_DBUF) begin
				dbuf_q <= cfg_wdata[0];
			end
		end
	end

	// Address decode
	logic [WW-1:0] addr_w, s_w, s2_w, mapped_w, offset_w;
	logic          in_front, in_back, in_ctl, off_ok;
	logic          wr_front, wr_back, ctl_hit, do_swap, do_redraw;
	dbfb_pkg::ctl_t    ctl;
	dbfb_pkg::status_t dec_status;
	logic [AW-1:0]     back_idx;

	assign addr_w   = {1'b0, address};
	assign s_w      = WW'(frame_q);
	assign s2_w     = s_w << 1;
	assign mapped_w = dbuf_q ? s2_w : s_w;
	assign offset_w = addr_w - mapped_w;
	assign in_front = addr_w < s_w;
	assign in_back  = dbuf_q && (addr_w < s2_w);
	assign in_ctl   = addr_w >= mapped_w;
	assign off_ok   = (offset_w[WW-1:2] == '0);
	assign ctl      = dbfb_pkg::ctl_t'(offset_w[1:0]);
	assign back_idx = AW'(addr_w - s_w);

	assign wr_front  = operation && in_front;
	assign wr_back   = operation && !in_front && in_back;
	assign ctl_hit   = operation && !in_front && !in_back && in_ctl;
	assign do_swap   = ctl_hit && off_ok && ctl == dbfb_pkg::CTL_SWAP && dbuf_q;
	assign do_redraw = ctl_hit && off_ok && ctl == dbfb_pkg::CTL_REDRAW;

	always_comb begin
		dec_status = dbfb_pkg::ST_OK;
		if (!operation) begin
			if (!in_front) begin
				dec_status = dbfb_pkg::ST_BAD_ADDR;
			end
		end else if (wr_front || wr_back) begin
			dec_status = dbfb_pkg::ST_OK;
		end else if (ctl_hit) begin
			if (!off_ok) begin
				dec_status = dbfb_pkg::ST_UNMAPPED;
			end else begin
				case (ctl)
					dbfb_pkg::CTL_CLEAR:  dec_status = dbfb_pkg::ST_OK;
					dbfb_pkg::CTL_SWAP: begin
						dec_status = dbuf_q ? dbfb_pkg::ST_OK : dbfb_pkg::ST_NO_BACK;
					end
					dbfb_pkg::CTL_REDRAW: dec_status = dbfb_pkg::ST_OK;
					dbfb_pkg::CTL_CRASH:  dec_status = dbfb_pkg::ST_INVALID;
					default:              dec_status = dbfb_pkg::ST_UNMAPPED;
				endcase
			end
		end else begin
			dec_status = dbfb_pkg::ST_BAD_ADDR;
		end
	end

	assign stat.is_read     = !operation;
	assign stat.is_clear    = ctl_hit && off_ok && ctl == dbfb_pkg::CTL_CLEAR;
	assign stat.frame_empty = (frame_q == '0);
	assign stat.init_last   = (cnt_q == LAST_ENTRY);
	assign stat.clear_last  = (cnt_q == AW'(frame_q - 1'b1));

	// Sweep counter, shared by the reset pass and the clear command
	logic sweeping, last;

	assign sweeping = cmd.init_sweep || cmd.clear_sweep;
	assign last     = cmd.init_sweep ? stat.init_last : stat.clear_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			front_is_b_q <= 1'b0;
			redraw_q     <= 1'b0;
		end else begin
			if (sweeping) begin
				cnt_q <= last ? '0 : cnt_q + 1'b1;
			end
			if (cmd.accept && do_swap) begin
				front_is_b_q <= !front_is_b_q;
			end
			if (cmd.accept && do_redraw) begin
				redraw_q <= 1'b1;
			end
		end
	end

	// Store write ports
	logic          a_we, b_we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rd_a, rd_b;

	assign a_we = cmd.init_sweep || (cmd.clear_sweep && !front_is_b_q) ||
		(cmd.accept && ((wr_front && !front_is_b_q) || (wr_back && front_is_b_q)));
	assign b_we = cmd.init_sweep || (cmd.clear_sweep && front_is_b_q) ||
		(cmd.accept && ((wr_front && front_is_b_q) || (wr_back && !front_is_b_q)));
	assign waddr = sweeping ? cnt_q : (wr_front ? address[AW-1:0] : back_idx);
	assign wdata = sweeping ? 8'd0 : write_data;
	assign raddr = address[AW-1:0];

	dbfb_ram #(
		.WIDTH(dbfb_pkg::DATA_W),
		.DEPTH(MAX_BUFFER_BYTES)
	) u_store_a (
		.clk  (clk),
		.we   (a_we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_a)
	);

	dbfb_ram #(
		.WIDTH(dbfb_pkg::DATA_W),
		.DEPTH(MAX_BUFFER_BYTES)
	) u_store_b (
		.clk  (clk),
		.we   (b_we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_b)
	);

	// Result register; a read beyond the frame keeps its zero byte
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rdata_q  <= 8'd0;
			status_q <= dec_status;
		end else if (cmd.load_rd && status_q == dbfb_pkg::ST_OK) begin
			rdata_q <= front_is_b_q ? rd_b : rd_a;
		end
	end

	assign read_data      = rdata_q;
	assign status         = status_q;
	assign redraw_pending = redraw_q;
	assign front_select   = front_is_b_q;

endmodule

/* hw/rtl/double_buffered_framebuffer.sv */
// ----------------------------------------------------------------------------
// double_buffered_framebuffer: memory-mapped RGB framebuffer, top level
// Byte-addressed front/back buffer with control registers above them.
// ----------------------------------------------------------------------------
// Each bus beat on the input channel returns exactly one result beat. The
// frame size S is width*height*3 bytes, capped at MAX_BUFFER_BYTES. Reads
// return a front-buffer byte for addresses below S. Writes below S go to
// the front buffer, writes in [S, 2S) go to the back buffer when double
// buffering is on, and writes at and above the mapped region hit control
// offsets: 0 clear front, 1 swap, 2 set redraw, 3 crash. A write that
// starts no clear sweep goes from the accept straight to the result beat;
// every read, out-of-range ones included, passes a read wait state first,
// since the store has a registered read port. A clear of a non-empty frame
// sweeps S bytes: one sweep counter writes one zero byte per cycle into the
// front store. Accepts resume once the result beat has been taken. After
// reset both stores are zeroed by a pass over all MAX_BUFFER_BYTES
// entries (16384 by default) before the first beat is accepted. Config
// writes are taken throughout and take effect on the edge of the write.
// ----------------------------------------------------------------------------
module double_buffered_framebuffer #(
	parameter int MAX_BUFFER_BYTES = dbfb_pkg::MAX_BUFFER_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [dbfb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_wdata,
	// bus access channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           operation,
	input  logic [dbfb_pkg::ADDR_W-1:0]    address,
	input  logic [dbfb_pkg::DATA_W-1:0]    write_data,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [dbfb_pkg::DATA_W-1:0]    read_data,
	output logic [2:0]                     status,
	output logic                           redraw_pending,
	output logic                           front_select
);

	dbfb_pkg::dbfb_cmd_t  cmd;
	dbfb_pkg::dbfb_stat_t stat;

	// Sequencer: reset pass, access, read wait, clear sweep, result beat
	dbfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Stores, decode and result register
	dbfb_dp #(
		.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.operation     (operation),
		.address       (address),
		.write_data    (write_data),
		.cmd           (cmd),
		.stat          (stat),
		.read_data     (read_data),
		.status        (status),
		.redraw_pending(redraw_pending),
		.front_select  (front_select)
	);

endmodule
